[src/hsl_pkg.sv]
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types for the HSL to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

    // Hue ramp segment for one colour channel
    typedef enum logic [1:0] {
        RGN_UP,     // rising edge: p + d*6t
        RGN_Q,      // plateau at q
        RGN_DOWN,   // falling edge: p + d*(2/3 - t)*6
        RGN_P       // floor at p
    } ramp_rgn_t;

    // Per-stage load enables, stage 1 nearest the input
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

[src/hsl_front.sv]
// ----------------------------------------------------------------------------
// hsl_front
// Stage 1: saturates S and L to one and forms the L*S product.
// ----------------------------------------------------------------------------
module hsl_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [FRAC_BITS:0]       saturation,
    input  logic [FRAC_BITS:0]       lightness,
    output logic [FRAC_BITS:0]       s_reg,
    output logic [FRAC_BITS:0]       l_reg,
    output logic [2*FRAC_BITS+1:0]   ls_reg,
    output logic                     s_zero_reg
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0]     s_next;
    logic [FRAC_BITS:0]     l_next;
    logic [2*FRAC_BITS+1:0] ls_next;

    always_comb begin
        s_next  = (saturation > ONE) ? ONE : saturation;
        l_next  = (lightness > ONE) ? ONE : lightness;
        ls_next = (2*FRAC_BITS+2)'(s_next) * (2*FRAC_BITS+2)'(l_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg      <= s_next;
            l_reg      <= l_next;
            ls_reg     <= ls_next;
            s_zero_reg <= (s_next == '0);
        end
    end

endmodule

[src/hsl_pq.sv]
// ----------------------------------------------------------------------------
// hsl_pq
// Stage 2: forms q, p and the span d = q - p shared by all three channels.
// ----------------------------------------------------------------------------
module hsl_pq #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [FRAC_BITS:0]       s,
    input  logic [FRAC_BITS:0]       l,
    input  logic [2*FRAC_BITS+1:0]   ls,
    input  logic                     s_zero,
    output logic [FRAC_BITS+1:0]     p_reg,
    output logic [FRAC_BITS+1:0]     q_reg,
    output logic [FRAC_BITS+1:0]     d_reg,
    output logic [FRAC_BITS:0]       l_reg,
    output logic                     grey_reg
);

    localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    logic [FRAC_BITS+1:0] ls_sh;
    logic [FRAC_BITS+1:0] twol;
    logic [FRAC_BITS+1:0] q_next;
    logic [FRAC_BITS+1:0] p_next;
    logic [FRAC_BITS+1:0] d_next;

    always_comb begin
        ls_sh = ls[2*FRAC_BITS+1:FRAC_BITS];
        twol  = {l, 1'b0};
        // l*(1+s) == l + l*s exactly, since l*ONE has no fraction to drop
        if (l < HALF) begin
            q_next = {1'b0, l} + ls_sh;
        end else begin
            q_next = {1'b0, l} + {1'b0, s} - ls_sh;
        end
        p_next = (twol > q_next) ? (twol - q_next) : '0;
        d_next = (q_next > p_next) ? (q_next - p_next) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            d_reg    <= d_next;
            l_reg    <= l;
            grey_reg <= s_zero;
        end
    end

endmodule

[src/hsl_ramp.sv]
// ----------------------------------------------------------------------------
// hsl_ramp
// One colour channel lane: hue segment decode, ramp multiply, final select.
// ----------------------------------------------------------------------------
module hsl_ramp
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  pipe_en_t                 en,
    input  logic [FRAC_BITS-1:0]     t,
    input  logic [FRAC_BITS+1:0]     p,
    input  logic [FRAC_BITS+1:0]     q,
    input  logic [FRAC_BITS+1:0]     d,
    input  logic [FRAC_BITS:0]       l,
    input  logic                     grey,
    output logic [FRAC_BITS:0]       chan_reg
);

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] SIXTH      = FRAC_BITS'(ONE_L / 6);
    localparam logic [FRAC_BITS-1:0] HALF       = FRAC_BITS'(ONE_L / 2);
    localparam logic [FRAC_BITS-1:0] TWO_THIRDS = FRAC_BITS'((2 * ONE_L) / 3);
    localparam logic [FRAC_BITS:0]   ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int PROD_W = 2*FRAC_BITS + 3;

    // stage 1: segment decode
    ramp_rgn_t            rgn1_reg, rgn1_next;
    logic [FRAC_BITS:0]   fac1_reg, fac1_next;
    logic [FRAC_BITS-1:0] fall;
    logic [FRAC_BITS-1:0] x;
    logic [FRAC_BITS+2:0] x6;

    always_comb begin
        fall = TWO_THIRDS - t;
        if (t < SIXTH) begin
            rgn1_next = RGN_UP;
            x         = t;
        end else if (t < HALF) begin
            rgn1_next = RGN_Q;
            x         = '0;
        end else if (t < TWO_THIRDS) begin
            rgn1_next = RGN_DOWN;
            x         = fall;
        end else begin
            rgn1_next = RGN_P;
            x         = '0;
        end
        // 6x as 4x + 2x; never exceeds ONE inside a ramp segment
        x6        = (FRAC_BITS+3)'({x, 2'b00}) + (FRAC_BITS+3)'({x, 1'b0});
        fac1_next = x6[FRAC_BITS:0];
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            rgn1_reg <= rgn1_next;
            fac1_reg <= fac1_next;
        end
    end

    // stage 2: wait for p/q/d
    ramp_rgn_t          rgn2_reg;
    logic [FRAC_BITS:0] fac2_reg;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            rgn2_reg <= rgn1_reg;
            fac2_reg <= fac1_reg;
        end
    end

    // stage 3: d * ramp factor
    logic [PROD_W-1:0]    prod_reg, prod_next;
    ramp_rgn_t            rgn3_reg;
    logic [FRAC_BITS+1:0] p3_reg;
    logic [FRAC_BITS+1:0] q3_reg;
    logic [FRAC_BITS:0]   l3_reg;
    logic                 grey3_reg;

    assign prod_next = PROD_W'(d) * PROD_W'(fac2_reg);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            prod_reg  <= prod_next;
            rgn3_reg  <= rgn2_reg;
            p3_reg    <= p;
            q3_reg    <= q;
            l3_reg    <= l;
            grey3_reg <= grey;
        end
    end

    // stage 4: select, clamp, grey override
    logic [FRAC_BITS+3:0] v;
    logic [FRAC_BITS:0]   chan_next;

    always_comb begin
        case (rgn3_reg) inside
            RGN_UP, RGN_DOWN: v = (FRAC_BITS+4)'(p3_reg)
                                  + (FRAC_BITS+4)'(prod_reg[PROD_W-1:FRAC_BITS]);
            RGN_Q:            v = (FRAC_BITS+4)'(q3_reg);
            default:          v = (FRAC_BITS+4)'(p3_reg);
        endcase
        if (grey3_reg) begin
            chan_next = l3_reg;
        end else if (v > (FRAC_BITS+4)'(ONE)) begin
            chan_next = ONE;
        end else begin
            chan_next = v[FRAC_BITS:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            chan_reg <= chan_next;
        end
    end

endmodule

[src/hsl_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Pipelined HSL to RGB conversion, one pixel per clock unless m_ready stalls.
// ----------------------------------------------------------------------------
// Converts a hue / saturation / lightness beat into a red / green / blue beat.
// Hue is a fraction of a turn (value / 2^FRAC_BITS); saturation, lightness and
// the outputs are unsigned fixed point where 2^FRAC_BITS means 1.0, and
// saturation or lightness above one are taken as one. Zero saturation gives
// grey at the lightness level. Products truncate, outputs clamp to 0..1.0.
// Throughput is one beat per clock unless m_ready stalls. There are four
// register stages; the accepting edge loads the first, and the beat then
// passes through the other three to m_*. The four stages are: S/L clamp
// and L*S multiply, q/p/span formation, one ramp multiply per channel, and
// the final segment select and clamp into the output register. Back-pressure
// on m_ready stalls only the stages that hold data, so bubbles are squeezed
// out and no beat is lost or repeated. No state survives between beats.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FRAC_BITS-1:0] s_hue,
    input  logic [FRAC_BITS:0]   s_saturation,
    input  logic [FRAC_BITS:0]   s_lightness,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAC_BITS:0]   m_red,
    output logic [FRAC_BITS:0]   m_green,
    output logic [FRAC_BITS:0]   m_blue
);

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'(ONE_L / 3);

    // ---- pipeline control ----
    // Each stage loads when it is empty or its successor is loading.
    logic [3:0] valid_reg, valid_next;
    pipe_en_t   en;

    always_comb begin
        en.s4 = !valid_reg[3] || m_ready;
        en.s3 = !valid_reg[2] || en.s4;
        en.s2 = !valid_reg[1] || en.s3;
        en.s1 = !valid_reg[0] || en.s2;

        valid_next = valid_reg;
        if (en.s1) valid_next[0] = s_valid;
        if (en.s2) valid_next[1] = valid_reg[0];
        if (en.s3) valid_next[2] = valid_reg[1];
        if (en.s4) valid_next[3] = valid_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en.s1;
    assign m_valid = valid_reg[3];

    // ---- stage 1: clamp and L*S ----
    logic [FRAC_BITS:0]     s1_s;
    logic [FRAC_BITS:0]     s1_l;
    logic [2*FRAC_BITS+1:0] s1_ls;
    logic                   s1_s_zero;

    hsl_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .en         (en.s1),
        .saturation (s_saturation),
        .lightness  (s_lightness),
        .s_reg      (s1_s),
        .l_reg      (s1_l),
        .ls_reg     (s1_ls),
        .s_zero_reg (s1_s_zero)
    );

    // ---- stage 2: q, p, span ----
    logic [FRAC_BITS+1:0] s2_p;
    logic [FRAC_BITS+1:0] s2_q;
    logic [FRAC_BITS+1:0] s2_d;
    logic [FRAC_BITS:0]   s2_l;
    logic                 s2_grey;

    hsl_pq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pq (
        .aclk     (aclk),
        .en       (en.s2),
        .s        (s1_s),
        .l        (s1_l),
        .ls       (s1_ls),
        .s_zero   (s1_s_zero),
        .p_reg    (s2_p),
        .q_reg    (s2_q),
        .d_reg    (s2_d),
        .l_reg    (s2_l),
        .grey_reg (s2_grey)
    );

    // ---- stages 1 to 4: per-channel ramp lanes ----
    // Red sits a third of a turn ahead, blue a third behind; both wrap.
    logic [FRAC_BITS-1:0] t_red;
    logic [FRAC_BITS-1:0] t_blue;

    assign t_red  = s_hue + THIRD;
    assign t_blue = s_hue - THIRD;

    hsl_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp_red (
        .aclk     (aclk),
        .en       (en),
        .t        (t_red),
        .p        (s2_p),
        .q        (s2_q),
        .d        (s2_d),
        .l        (s2_l),
        .grey     (s2_grey),
        .chan_reg (m_red)
    );

    hsl_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp_green (
        .aclk     (aclk),
        .en       (en),
        .t        (s_hue),
        .p        (s2_p),
        .q        (s2_q),
        .d        (s2_d),
        .l        (s2_l),
        .grey     (s2_grey),
        .chan_reg (m_green)
    );

    hsl_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp_blue (
        .aclk     (aclk),
        .en       (en),
        .t        (t_blue),
        .p        (s2_p),
        .q        (s2_q),
        .d        (s2_d),
        .l        (s2_l),
        .grey     (s2_grey),
        .chan_reg (m_blue)
    );

endmodule

[bench/hsl_rgb_checker.sv]
// ----------------------------------------------------------------------------
// hsl_rgb_checker
// Watches both channels of the HSL to RGB converter and scores each result.
// ----------------------------------------------------------------------------
// Every accepted input beat is converted to its expected colour and queued.
// Every accepted output beat is matched, channel by channel, against the
// oldest expected colour. The failure count and the number of colours still
// expected are passed up to the testbench top.
// ----------------------------------------------------------------------------
module hsl_rgb_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [FRAC_BITS-1:0] s_hue,
    input  logic [FRAC_BITS:0]   s_saturation,
    input  logic [FRAC_BITS:0]   s_lightness,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [FRAC_BITS:0]   m_red,
    input  logic [FRAC_BITS:0]   m_green,
    input  logic [FRAC_BITS:0]   m_blue,
    output int                   errors,
    output int                   awaiting
);

    localparam longint unsigned ONE        = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF       = ONE / 2;
    localparam longint unsigned THIRD      = ONE / 3;
    localparam longint unsigned SIXTH      = ONE / 6;
    localparam longint unsigned TWO_THIRDS = (2 * ONE) / 3;

    typedef struct packed {
        logic [FRAC_BITS:0] red;
        logic [FRAC_BITS:0] green;
        logic [FRAC_BITS:0] blue;
    } rgb_t;

    rgb_t colours_due[$];
    int   result_beats = 0;

    function automatic longint unsigned clip_one(input longint unsigned v);
        return (v > ONE) ? ONE : v;
    endfunction

    // Piecewise hue ramp for one channel at turn position t
    function automatic longint unsigned channel_level(input longint unsigned p,
                                                      input longint unsigned q,
                                                      input longint unsigned t);
        longint unsigned span;
        longint unsigned v;
        span = (q > p) ? q - p : 0;
        if (t < SIXTH)
            v = p + ((span * 6 * t) >> FRAC_BITS);
        else if (t < HALF)
            v = q;
        else if (t < TWO_THIRDS)
            v = p + ((span * (TWO_THIRDS - t) * 6) >> FRAC_BITS);
        else
            v = p;
        return clip_one(v);
    endfunction

    function automatic rgb_t convert_pixel(input logic [FRAC_BITS-1:0] hue,
                                           input logic [FRAC_BITS:0]   sat_in,
                                           input logic [FRAC_BITS:0]   lit_in);
        longint unsigned h;
        longint unsigned s;
        longint unsigned l;
        longint unsigned q;
        longint unsigned p;
        rgb_t            c;
        h = hue;
        s = clip_one(sat_in);
        l = clip_one(lit_in);
        if (s == 0) begin
            c.red   = l[FRAC_BITS:0];
            c.green = l[FRAC_BITS:0];
            c.blue  = l[FRAC_BITS:0];
        end else begin
            if (l < HALF)
                q = (l * (ONE + s)) >> FRAC_BITS;
            else
                q = l + s - ((l * s) >> FRAC_BITS);
            p = (2 * l > q) ? 2 * l - q : 0;
            c.red   = (FRAC_BITS + 1)'(channel_level(p, q, (h + THIRD) % ONE));
            c.green = (FRAC_BITS + 1)'(channel_level(p, q, h));
            c.blue  = (FRAC_BITS + 1)'(channel_level(p, q, (h + ONE - THIRD) % ONE));
        end
        return c;
    endfunction

    // One line and one count per failure
    task automatic flag_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    always @(posedge aclk) begin
        rgb_t due;
        if (!aresetn) begin
            errors = 0;
            colours_due.delete();
            awaiting <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (colours_due.size() == 0) begin
                    flag_mismatch($sformatf("result beat %0d with no colour expected",
                                            result_beats));
                end else begin
                    due = colours_due.pop_front();
                    if (m_red !== due.red)
                        flag_mismatch($sformatf("beat %0d red: expected %0d, got %0d",
                                                result_beats, due.red, m_red));
                    if (m_green !== due.green)
                        flag_mismatch($sformatf("beat %0d green: expected %0d, got %0d",
                                                result_beats, due.green, m_green));
                    if (m_blue !== due.blue)
                        flag_mismatch($sformatf("beat %0d blue: expected %0d, got %0d",
                                                result_beats, due.blue, m_blue));
                end
                result_beats++;
            end
            if (s_valid && s_ready)
                colours_due.insert(colours_due.size(),
                                   convert_pixel(s_hue, s_saturation, s_lightness));
            awaiting <= colours_due.size();
        end
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Regression bench for the HSL to RGB converter.
// ----------------------------------------------------------------------------
// A short directed set hits grey, the primaries, the hue ramp segment edges
// and saturation / lightness above one; then about 1100 random pixels follow,
// weighted towards edge values. Both channels idle in random bursts, except
// in the final stretch. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC_BITS    = 16;
    localparam int ONE          = 1 << FRAC_BITS;
    localparam int HALF         = ONE / 2;
    localparam int THIRD        = ONE / 3;
    localparam int SIXTH        = ONE / 6;
    localparam int TWO_THIRDS   = (2 * ONE) / 3;
    localparam int RANDOM_BEATS = 1100;
    localparam int TAIL_BEATS   = 150;     // final stretch with no idling
    localparam int DRAIN_CYCLES = 12;      // extra clocks after the last colour is matched
    localparam int CYCLE_LIMIT  = 400000;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic [FRAC_BITS-1:0] s_hue        = '0;
    logic [FRAC_BITS:0]   s_saturation = '0;
    logic [FRAC_BITS:0]   s_lightness  = '0;
    logic                 m_ready      = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [FRAC_BITS:0]   m_red;
    logic [FRAC_BITS:0]   m_green;
    logic [FRAC_BITS:0]   m_blue;

    int errors;
    int awaiting;
    int cycles      = 0;
    int ready_hold  = 0;
    int gap_odds    = 0;    // 0: no input gaps, n: a gap before one beat in n
    bit quiet_tail  = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hsl_to_rgb_converter #(
        .FRAC_BITS    (FRAC_BITS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    hsl_rgb_checker #(
        .FRAC_BITS    (FRAC_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .errors       (errors),
        .awaiting     (awaiting)
    );

    // Watchdog: a hung handshake or lost beat ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("hsl_to_rgb_converter regression: fail");
            $finish;
        end
    end

    // Result side back-pressure: m_ready holds each level for a run set by
    // ready_hold; stall runs are drawn from a shorter range than ready runs so
    // the pipeline sees both full throughput and stalls landing on every stage.
    always @(posedge aclk) begin
        if (quiet_tail) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 40);
        end
    end

    // Present one pixel and hold it until the beat is taken. Valid is only
    // dropped when a gap is inserted, so back-to-back beats never see valid
    // lowered and raised in the same step.
    task automatic send_pixel(input logic [FRAC_BITS-1:0] hue,
                              input logic [FRAC_BITS:0]   sat,
                              input logic [FRAC_BITS:0]   lit);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_lightness  <= lit;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hue near a ramp segment edge as seen by one of the three channels
    // (red looks a third ahead, blue a third behind), else anywhere.
    function automatic logic [FRAC_BITS-1:0] pick_hue();
        int seg_edge;
        int offset;
        int h;
        if ($urandom_range(0, 3) != 0)
            return FRAC_BITS'($urandom_range(0, ONE - 1));
        case ($urandom_range(0, 3))
            0:       seg_edge = 0;
            1:       seg_edge = SIXTH;
            2:       seg_edge = HALF;
            default: seg_edge = TWO_THIRDS;
        endcase
        case ($urandom_range(0, 2))
            0:       offset = 0;
            1:       offset = ONE - THIRD;
            default: offset = THIRD;
        endcase
        h = (seg_edge + offset + ONE + $urandom_range(0, 4) - 2) % ONE;
        return FRAC_BITS'(h);
    endfunction

    // Saturation or lightness: zero, one, above one, around the q switch
    // point at one half, tiny, or anywhere in range
    function automatic logic [FRAC_BITS:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return (FRAC_BITS + 1)'(ONE);
            2:       return (FRAC_BITS + 1)'($urandom_range(ONE + 1, 2 * ONE - 1));
            3:       return (FRAC_BITS + 1)'($urandom_range(HALF - 2, HALF + 2));
            4:       return (FRAC_BITS + 1)'($urandom_range(0, 15));
            default: return (FRAC_BITS + 1)'($urandom_range(0, ONE));
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: greys, primaries, segment edges and out-of-range levels
        send_pixel('0,                  '0,            '0);
        send_pixel(FRAC_BITS'(ONE - 1), '0,            17'(ONE));
        send_pixel(FRAC_BITS'(12345),   '0,            17'(2 * ONE - 1));  // grey clipped
        send_pixel('0,                  17'(ONE),      17'(HALF));         // pure red
        send_pixel(FRAC_BITS'(THIRD),   17'(ONE),      17'(HALF));         // pure green
        send_pixel(FRAC_BITS'(TWO_THIRDS), 17'(ONE),   17'(HALF));         // pure blue
        send_pixel(FRAC_BITS'(SIXTH - 1),  17'(ONE),   17'(HALF));
        send_pixel(FRAC_BITS'(SIXTH),      17'(ONE),   17'(HALF));
        send_pixel(FRAC_BITS'(HALF - 1),   17'(ONE),   17'(HALF));
        send_pixel(FRAC_BITS'(HALF),       17'(ONE),   17'(HALF));
        send_pixel(FRAC_BITS'(TWO_THIRDS - 1), 17'(ONE), 17'(HALF));
        send_pixel(FRAC_BITS'(ONE - 1),    17'(ONE),   17'(HALF));
        send_pixel(FRAC_BITS'(ONE - THIRD), 17'(40000), 17'(30000));
        send_pixel(FRAC_BITS'(1000),   17'(2 * ONE - 1), 17'(30000));      // sat above one
        send_pixel(FRAC_BITS'(1000),   17'(ONE + 1),     17'(40000));
        send_pixel(FRAC_BITS'(5000),   17'(40000),       17'(HALF - 1));   // q switch point
        send_pixel(FRAC_BITS'(5000),   17'(40000),       17'(HALF));
        send_pixel(FRAC_BITS'(7000),   17'(ONE),         17'(ONE));        // white
        send_pixel(FRAC_BITS'(7000),   17'(ONE),         '0);              // black
        send_pixel(FRAC_BITS'(20000),  17'(20000),       17'(100000));     // lit above one
        send_pixel(FRAC_BITS'(12345),  17'(1),           17'(1));
        send_pixel(FRAC_BITS'(ONE - 1), 17'(2 * ONE - 1), 17'(2 * ONE - 1));

        // Random: gap density changes every 64 beats, none in the tail
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == RANDOM_BEATS - TAIL_BEATS) begin
                quiet_tail <= 1'b1;
                gap_odds    = 0;
            end else if (i % 64 == 0 && i < RANDOM_BEATS - TAIL_BEATS) begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 8;
                    default: gap_odds = 2;
                endcase
            end
            send_pixel(pick_hue(), pick_level(), pick_level());
        end
        s_valid <= 1'b0;

        // Drain: the checker's count is registered, so step before testing
        do @(posedge aclk); while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("hsl_to_rgb_converter regression: pass");
        else
            $display("hsl_to_rgb_converter regression: fail");
        $finish;
    end

endmodule
